### hdl/sidac_pkg.sv
// Shared constants, types and a divide-by-ten function for the signed decimal text converter.
`default_nettype none
package sidac_pkg;
	localparam int unsigned ValueWidth = 32;
	localparam int unsigned CharWidth = 7;
	localparam int unsigned NumDigits = 10;
	localparam int unsigned DigitsPerStage = 1;
	localparam int unsigned NumStages = NumDigits / DigitsPerStage;
	localparam int unsigned CountWidth = 4;
	localparam logic [CharWidth-1:0] CharZero = 7'd48;
	localparam logic [CharWidth-1:0] CharMinus = 7'd45;

	typedef logic [3:0] digit_t;

	typedef struct packed {
		logic [ValueWidth-1:0] rem;
		logic [NumDigits*4-1:0] digits;
		logic negative;
	} conv_t;

	// Quotient and remainder of a 32-bit value by ten: reciprocal multiply and fix-up.
	function automatic logic [ValueWidth+3:0] div10(input logic [ValueWidth-1:0] v);
		logic [2*ValueWidth:0] prod;
		logic [ValueWidth-1:0] q;
		logic [ValueWidth-1:0] r;
		prod = {1'b0, v} * {1'b0, 32'hCCCC_CCCD};
		q = {3'b000, prod[2*ValueWidth-1:ValueWidth+3]};
		r = v - ((q << 3) + (q << 1));
		if (r >= 32'd10) begin
			q = q + 32'd1;
			r = r - 32'd10;
		end
		return {q, r[3:0]};
	endfunction
endpackage
`default_nettype wire

### hdl/sidac_stage.sv
// One pipeline stage that peels one decimal digit off the remaining magnitude.
`default_nettype none
module sidac_stage
	import sidac_pkg::*;
#(
	parameter int unsigned StageIndex = 0
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic en,
	input wire logic in_valid,
	input conv_t in_data,
	output logic out_valid,
	output conv_t out_data
);
	logic [ValueWidth+3:0] d0;
	conv_t nxt;

	always_comb begin
		d0 = div10(in_data.rem);
		nxt = in_data;
		nxt.rem = d0[ValueWidth+3:4];
		nxt.digits[StageIndex*4+:4] = d0[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && in_valid) begin
			out_data <= nxt;
		end
	end
endmodule
`default_nettype wire

### hdl/sidac_emit.sv
// Character emitter: walks the digit string out one transfer per cycle while out_ready is high.
`default_nettype none
module sidac_emit
	import sidac_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input conv_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output logic [CharWidth-1:0] out_char,
	output logic out_last
);
	logic busy_q;
	logic sign_q;
	logic [NumDigits*4-1:0] digits_q;
	logic [CountWidth-1:0] idx_q;
	logic [CountWidth-1:0] top;
	digit_t cur;

	always_comb begin
		top = '0;
		for (int i = 1; i < NumDigits; i++) begin
			if (in_data.digits[i*4+:4] != 4'd0) begin
				top = CountWidth'(i);
			end
		end
	end

	assign cur = digits_q[idx_q*4+:4];
	assign out_valid = busy_q;
	assign out_char = sign_q ? CharMinus : CharZero + {3'd0, cur};
	assign out_last = !sign_q && (idx_q == '0);
	assign in_ready = !busy_q || (out_ready && out_last);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (in_valid && in_ready) begin
			busy_q <= 1'b1;
		end else if (out_ready && out_last) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			sign_q <= in_data.negative;
			digits_q <= in_data.digits;
			idx_q <= top;
		end else if (busy_q && out_ready) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				idx_q <= idx_q - CountWidth'(1);
			end
		end
	end
endmodule
`default_nettype wire

### hdl/signed_int_to_decimal_ascii_core.sv
// Top level of the signed integer to decimal ASCII converter.
// The input passes the digit stages and then the emitter before its first character transfer.
// Throughput: one character per cycle while m_axis_tready is high; the emitter takes
// the next value as the last character transfers. Its single output port sets that figure.
// Reset clears all valid bits; payload registers are not reset.
`default_nettype none
module signed_int_to_decimal_ascii_core
	import sidac_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_axis_tvalid,
	output logic s_axis_tready,
	input wire logic [31:0] s_axis_tdata, // value[31:0]
	output logic m_axis_tvalid,
	input wire logic m_axis_tready,
	output logic [7:0] m_axis_tdata, // char_code[6:0], zero[7]
	output logic m_axis_tlast
);
	logic en;
	logic v [NumStages+1];
	conv_t d [NumStages+1];
	logic e_ready;
	logic [CharWidth-1:0] ch;

	assign en = !v[NumStages] || e_ready;
	assign s_axis_tready = en;
	assign v[0] = s_axis_tvalid;
	assign d[0].negative = s_axis_tdata[31];
	assign d[0].rem = s_axis_tdata[31] ? 32'd0 - s_axis_tdata : s_axis_tdata;
	assign d[0].digits = '0;

	for (genvar g = 0; g < NumStages; g++) begin : g_st
		sidac_stage #(.StageIndex(g)) u_st (
			.clk(clk), .arst_n(arst_n), .en(en),
			.in_valid(v[g]), .in_data(d[g]),
			.out_valid(v[g+1]), .out_data(d[g+1])
		);
	end

	sidac_emit u_emit (
		.clk(clk), .arst_n(arst_n),
		.in_valid(v[NumStages]), .in_ready(e_ready), .in_data(d[NumStages]),
		.out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
		.out_char(ch), .out_last(m_axis_tlast)
	);
	assign m_axis_tdata = {1'b0, ch};

	a_char: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (ch == CharMinus) || (ch >= CharZero && ch <= CharZero + 7'd9))
		else $error("bad character");
	a_minus_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && ch == CharMinus) |-> !m_axis_tlast)
		else $error("minus flagged last");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output dropped");
endmodule
`default_nettype wire

### bench/signed_int_to_decimal_ascii_core_tb.sv
// Testbench for the signed integer to decimal ASCII converter: directed and random values, checked against a predictor.
`timescale 1ns / 1ps
`default_nettype none
module signed_int_to_decimal_ascii_core_tb
	import sidac_pkg::*;
;

	typedef struct packed {
		logic [CharWidth-1:0] code;
		logic is_last;
	} char_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [31:0] s_axis_tdata = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [7:0] m_axis_tdata;
	logic m_axis_tlast;

	char_t text_q[$];
	int errors = 0;
	int hold_cycles = 0;
	bit steady_rx = 1'b0;

	signed_int_to_decimal_ascii_core dut (.*);

	always #2 clk = ~clk;

	initial begin
		#400000;
		$display("signed_int_to_decimal_ascii_core test failed");
		$finish;
	end

	function automatic void predict_text(input logic [31:0] v);
		logic [31:0] mag;
		logic [3:0] dig[10];
		int nd;
		char_t c;
		nd = 0;
		mag = v[31] ? 32'd0 - v : v;
		do begin
			dig[nd] = 4'(mag % 10);
			nd++;
			mag = mag / 10;
		end while (mag != 0);
		if (v[31]) begin
			c.code = CharMinus;
			c.is_last = 1'b0;
			text_q.push_back(c);
		end
		for (int k = nd - 1; k >= 0; k--) begin
			c.code = CharZero + 7'(dig[k]);
			c.is_last = (k == 0);
			text_q.push_back(c);
		end
	endfunction

	// hold tvalid high after the transfer; the caller drops it before any gap
	task automatic send_value(input logic [31:0] v);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		do @(posedge clk); while (!s_axis_tready);
		predict_text(v);
	endtask

	task automatic send_burst(input logic [31:0] v, input bit gappy);
		send_value(v);
		if (gappy && $urandom_range(0, 3) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// receiver stall pattern; forced low during a hold
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else if (steady_rx) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 9) < 7);
		end
	end

	always @(posedge clk) begin
		char_t exp_c;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (text_q.size() == 0) begin
				$display("%0t: unexpected transfer code %0d last %0b", $time,
					m_axis_tdata[6:0], m_axis_tlast);
				errors++;
			end else begin
				exp_c = text_q.pop_front();
				if (m_axis_tdata[6:0] !== exp_c.code || m_axis_tlast !== exp_c.is_last ||
						m_axis_tdata[7] !== 1'b0) begin
					$display("%0t: expected code %0d last %0b, got code %0d last %0b",
						$time, exp_c.code, exp_c.is_last, m_axis_tdata[6:0], m_axis_tlast);
					errors++;
				end
			end
		end
	end

	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (text_q.size() != 0) @(posedge clk);
	endtask

	task automatic test_extremes();
		logic [31:0] vals[] = '{32'd0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd1,
			32'd9, 32'd10, 32'd99, 32'd100, 32'hFFFF_FFF6, 32'hFFFF_FFF7, 32'd999999999,
			32'd1000000000, 32'hC465_3600, 32'hC465_3601, 32'h8000_0001, 32'd4294967,
			32'h5555_5555, 32'hAAAA_AAAA};
		foreach (vals[i]) send_value(vals[i]);
		wait_drained();
	endtask

	task automatic test_backpressure();
		hold_cycles = 200;
		repeat (30) send_value($urandom);
		wait_drained();
	endtask

	task automatic test_streaming();
		steady_rx = 1'b1;
		repeat (40) send_value($urandom);
		steady_rx = 1'b0;
		wait_drained();
	endtask

	task automatic test_random();
		int n;
		int burst;
		int gap;
		logic [31:0] v;
		n = 0;
		while (n < 360) begin
			burst = $urandom_range(1, 12);
			repeat (burst) begin
				case ($urandom_range(0, 3))
					0: v = $urandom;
					1: v = $urandom_range(0, 20000);
					2: v = 32'd0 - $urandom_range(0, 20000);
					default: v = $urandom >> $urandom_range(0, 31);
				endcase
				send_burst(v, 1'b1);
				n++;
			end
			gap = $urandom_range(0, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_backpressure();
		test_streaming();
		test_random();
		wait_drained();
		repeat (30) @(posedge clk);
		if (errors == 0 && text_q.size() == 0)
			$display("signed_int_to_decimal_ascii_core test passed");
		else
			$display("signed_int_to_decimal_ascii_core test failed");
		$finish;
	end
endmodule
`default_nettype wire

### signed_int_to_decimal_ascii_core.f
hdl/sidac_pkg.sv
hdl/sidac_stage.sv
hdl/sidac_emit.sv
hdl/signed_int_to_decimal_ascii_core.sv
bench/signed_int_to_decimal_ascii_core_tb.sv
